### src/tekd_pkg.sv
// Shared types, codes and constants for the terminal escape key decoder.
`timescale 1ns / 1ps

package tekd_pkg;

  localparam int MOUSE_REPORT_MAX = 31;
  localparam int COORD_BITS       = 12;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_MOUSE  = 2'd1;
  localparam logic [1:0] KIND_REDRAW = 2'd2;

  localparam logic [10:0] KEY_ESC    = 11'd27;
  localparam logic [10:0] KEY_HOME   = 11'd1000;
  localparam logic [10:0] KEY_DELETE = 11'd1001;
  localparam logic [10:0] KEY_UP     = 11'd1008;
  localparam logic [10:0] KEY_DOWN   = 11'd1009;
  localparam logic [10:0] KEY_RIGHT  = 11'd1010;
  localparam logic [10:0] KEY_LEFT   = 11'd1011;
  localparam logic [10:0] KEY_HOME2  = 11'd1012;
  localparam logic [10:0] KEY_END    = 11'd1013;
  localparam logic [10:0] KEY_MOUSE  = 11'd1014;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_Z = 8'h1A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UC     = 8'h43;
  localparam logic [7:0] CH_UD     = 8'h44;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_UM     = 8'h4D;
  localparam logic [7:0] CH_UO     = 8'h4F;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_LM     = 8'h6D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_ESC1   = 7'b0000010,
    PH_ESC2   = 7'b0000100,
    PH_CSIDIG = 7'b0001000,
    PH_MOD    = 7'b0010000,
    PH_FINAL  = 7'b0100000,
    PH_MOUSE  = 7'b1000000
  } phase_t;

  function automatic logic [10:0] arrow_code(input logic [7:0] c);
    logic [10:0] code;
    case (c)
      CH_UA:   code = KEY_UP;
      CH_UB:   code = KEY_DOWN;
      CH_UC:   code = KEY_RIGHT;
      CH_UD:   code = KEY_LEFT;
      CH_UH:   code = KEY_HOME2;
      CH_UF:   code = KEY_END;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

### src/terminal_escape_key_decoder.sv
// Top level: escape-sequence and SGR mouse report decoder for terminal input bytes.
//
//   channel  | dir | tdata                     | tuser
//   s_axis   | in  | data_byte                 | command
//   m_axis   | out | key, mods, mouse fields   | event_kind
//
// One word per cycle sustained while m_axis is not stalled. An accepted word is held
// in the input register, and one pass of the decode logic writes its result into
// the result register. A stall on m_axis holds the result register and a waiting
// input word; s_axis_tready drops once both are full. Synchronous reset returns
// the parser to idle and marks the kept mouse report invalid.
`timescale 1ns / 1ps

module terminal_escape_key_decoder #(
  parameter int MOUSE_REPORT_MAX = tekd_pkg::MOUSE_REPORT_MAX,
  parameter int COORD_BITS       = tekd_pkg::COORD_BITS,
  parameter int TDATA_W          = ((24 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tuser,   // [0] command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // key[11], shift, alt, ctrl, mouse_button[8], mouse_x, mouse_y,
  // mouse_pressed, mouse_released, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]         m_axis_tuser    // [1:0] event_kind
);

  localparam int ACC_W  = COORD_BITS + 1;
  localparam int PROD_W = ACC_W + 4;
  localparam int LEN_W  = $clog2(MOUSE_REPORT_MAX + 1);
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic                  released;
    logic                  pressed;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
    logic [7:0]            button;
    logic                  ctrl;
    logic                  alt;
    logic                  shift;
    logic [10:0]           key;
  } res_t;

  function automatic res_t key_res(input logic [10:0] key, input logic sh,
                                   input logic al, input logic ct);
    res_t r;
    r = '0;
    r.key   = key;
    r.shift = sh;
    r.alt   = al;
    r.ctrl  = ct | (key >= 11'd1 && key <= 11'(tekd_pkg::CH_CTRL_Z) &&
                    key != 11'(tekd_pkg::CH_TAB) && key != 11'(tekd_pkg::CH_CR));
    return r;
  endfunction

  // input register
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_byte;

  // parser state
  tekd_pkg::phase_t phase, phase_next;
  logic [7:0]       held_digit, held_digit_next;
  logic [7:0]       held_mod, held_mod_next;
  logic [LEN_W-1:0] rep_len, rep_len_next;
  logic [1:0]       field_idx, field_idx_next;
  logic [ACC_W-1:0] acc [3];
  logic [ACC_W-1:0] acc_next [3];
  logic [2:0]       digits_seen, digits_seen_next;
  logic             last_valid, last_valid_next;
  logic             last_release, last_release_next;
  logic [ACC_W-1:0] last_btn, last_btn_next;
  logic [ACC_W-1:0] last_x, last_x_next;
  logic [ACC_W-1:0] last_y, last_y_next;

  // result register
  logic       out_valid;
  logic [1:0] out_kind;
  res_t       out_res;

  logic       advance;
  logic       process;
  logic       has_res;
  logic [1:0] res_kind;
  res_t       res;

  logic             is_digit;
  logic [3:0]       digit_val;
  logic [LEN_W:0]   len_inc;
  logic             rep_end;
  logic [PROD_W-1:0] prod [3];

  // mouse decode source
  logic             md_valid;
  logic             md_release;
  logic [ACC_W-1:0] md_btn;
  logic [ACC_W-1:0] md_x;
  logic [ACC_W-1:0] md_y;
  logic [1:0]       md_kind;
  res_t             md_res;
  logic [ACC_W-1:0] md_xm1;
  logic [ACC_W-1:0] md_ym1;

  logic [7:0] mod_m;

  assign advance       = !out_valid || m_axis_tready;
  assign process       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = TDATA_W'(out_res);

  assign is_digit  = in_byte >= tekd_pkg::CH_0 && in_byte <= tekd_pkg::CH_9;
  assign digit_val = in_byte[3:0];
  assign len_inc   = (LEN_W + 1)'(rep_len) + (LEN_W + 1)'(1);
  assign rep_end   = in_byte == tekd_pkg::CH_UM || in_byte == tekd_pkg::CH_LM ||
                     len_inc >= (LEN_W + 1)'(MOUSE_REPORT_MAX);
  assign mod_m     = held_mod - tekd_pkg::CH_1;

  // accumulate one decimal digit into the selected mouse field
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (PROD_W'(acc[i]) << 3) + (PROD_W'(acc[i]) << 1) + PROD_W'(digit_val);
    end
  end

  // decode a finished or kept mouse report
  always_comb begin
    md_xm1 = md_x - ACC_W'(1);
    md_ym1 = md_y - ACC_W'(1);
    md_res = '0;
    md_kind = tekd_pkg::KIND_MOUSE;
    if (md_valid) begin
      if (md_x == '0 || md_y == '0) begin
        md_kind = tekd_pkg::KIND_REDRAW;
      end else begin
        md_res.key    = tekd_pkg::KEY_MOUSE;
        md_res.button = (md_btn > ACC_W'(255)) ? 8'hFF : md_btn[7:0];
        md_res.x      = md_xm1[ACC_W-1] ? '1 : md_xm1[COORD_BITS-1:0];
        md_res.y      = md_ym1[ACC_W-1] ? '1 : md_ym1[COORD_BITS-1:0];
        if (md_btn >= ACC_W'(64) && md_btn <= ACC_W'(67)) begin
          md_res.pressed = 1'b1;
        end else if (md_btn[5]) begin
          md_res.pressed = 1'b0;
        end else if (!md_release) begin
          md_res.pressed = 1'b1;
        end else begin
          md_res.released = 1'b1;
        end
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    held_digit_next   = held_digit;
    held_mod_next     = held_mod;
    rep_len_next      = rep_len;
    field_idx_next    = field_idx;
    acc_next          = acc;
    digits_seen_next  = digits_seen;
    last_valid_next   = last_valid;
    last_release_next = last_release;
    last_btn_next     = last_btn;
    last_x_next       = last_x;
    last_y_next       = last_y;
    has_res           = 1'b0;
    res_kind          = tekd_pkg::KIND_KEY;
    res               = '0;
    md_valid          = last_valid;
    md_release        = last_release;
    md_btn            = last_btn;
    md_x              = last_x;
    md_y              = last_y;

    if (in_cmd == tekd_pkg::CMD_TIMEOUT) begin
      has_res = 1'b1;
      if (phase == tekd_pkg::PH_IDLE) begin
        res_kind = tekd_pkg::KIND_REDRAW;
      end else begin
        phase_next = tekd_pkg::PH_IDLE;
        res        = key_res(tekd_pkg::KEY_ESC, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      case (phase)
        tekd_pkg::PH_IDLE: begin
          if (in_byte == tekd_pkg::CH_ESC) begin
            phase_next = tekd_pkg::PH_ESC1;
          end else if (in_byte == tekd_pkg::CH_NUL) begin
            has_res  = 1'b1;
            res_kind = tekd_pkg::KIND_REDRAW;
          end else begin
            has_res = 1'b1;
            res = key_res(11'(in_byte),
                          in_byte >= tekd_pkg::CH_UA && in_byte <= tekd_pkg::CH_UZ,
                          1'b0, 1'b0);
          end
        end
        tekd_pkg::PH_ESC1: begin
          held_digit_next = in_byte;
          phase_next      = tekd_pkg::PH_ESC2;
        end
        tekd_pkg::PH_ESC2: begin
          phase_next = tekd_pkg::PH_IDLE;
          has_res    = 1'b1;
          res        = key_res(tekd_pkg::KEY_ESC, 1'b0, 1'b0, 1'b0);
          if (held_digit == tekd_pkg::CH_LBRK) begin
            if (is_digit) begin
              held_digit_next = in_byte;
              phase_next      = tekd_pkg::PH_CSIDIG;
              has_res         = 1'b0;
            end else if (in_byte == tekd_pkg::CH_LT) begin
              last_valid_next  = 1'b0;
              rep_len_next     = '0;
              field_idx_next   = '0;
              digits_seen_next = '0;
              for (int i = 0; i < 3; i++) begin
                acc_next[i] = '0;
              end
              phase_next = tekd_pkg::PH_MOUSE;
              has_res    = 1'b0;
            end else if (in_byte == tekd_pkg::CH_UM) begin
              res_kind = md_kind;
              res      = md_res;
            end else if (tekd_pkg::arrow_code(in_byte) != '0) begin
              res = key_res(tekd_pkg::arrow_code(in_byte), 1'b0, 1'b0, 1'b0);
            end
          end else if (held_digit == tekd_pkg::CH_UO &&
                       (in_byte == tekd_pkg::CH_UH || in_byte == tekd_pkg::CH_UF)) begin
            res = key_res(tekd_pkg::arrow_code(in_byte), 1'b0, 1'b0, 1'b0);
          end
        end
        tekd_pkg::PH_CSIDIG: begin
          if (in_byte == tekd_pkg::CH_SEMI) begin
            phase_next = tekd_pkg::PH_MOD;
          end else begin
            phase_next = tekd_pkg::PH_IDLE;
            has_res    = 1'b1;
            res        = key_res(tekd_pkg::KEY_ESC, 1'b0, 1'b0, 1'b0);
            if (in_byte == tekd_pkg::CH_TILDE) begin
              if (held_digit == tekd_pkg::CH_1) begin
                res = key_res(tekd_pkg::KEY_HOME, 1'b0, 1'b0, 1'b0);
              end else if (held_digit >= tekd_pkg::CH_3 && held_digit <= tekd_pkg::CH_9) begin
                res = key_res(tekd_pkg::KEY_DELETE + 11'(held_digit[3:0]) - 11'd3,
                              1'b0, 1'b0, 1'b0);
              end
            end
          end
        end
        tekd_pkg::PH_MOD: begin
          held_mod_next = in_byte;
          phase_next    = tekd_pkg::PH_FINAL;
        end
        tekd_pkg::PH_FINAL: begin
          phase_next = tekd_pkg::PH_IDLE;
          has_res    = 1'b1;
          if (tekd_pkg::arrow_code(in_byte) == '0) begin
            res = key_res(tekd_pkg::KEY_ESC, 1'b0, 1'b0, 1'b0);
          end else if (held_mod >= tekd_pkg::CH_2 && held_mod <= tekd_pkg::CH_8) begin
            res = key_res(tekd_pkg::arrow_code(in_byte), mod_m[0], mod_m[1], mod_m[2]);
          end else begin
            res = key_res(tekd_pkg::arrow_code(in_byte), 1'b0, 1'b0, 1'b0);
          end
        end
        tekd_pkg::PH_MOUSE: begin
          rep_len_next = len_inc[LEN_W-1:0];
          if (field_idx != 2'd3) begin
            if (is_digit) begin
              for (int i = 0; i < 3; i++) begin
                if (field_idx == 2'(i)) begin
                  acc_next[i] = (prod[i] > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[i][ACC_W-1:0];
                  digits_seen_next[i] = 1'b1;
                end
              end
            end else if (in_byte == tekd_pkg::CH_SEMI && field_idx != 2'd2 &&
                         digits_seen[field_idx]) begin
              field_idx_next = field_idx + 2'd1;
            end else begin
              field_idx_next = 2'd3;
            end
          end
          if (rep_end) begin
            last_valid_next   = digits_seen_next[2];
            last_release_next = in_byte == tekd_pkg::CH_LM;
            last_btn_next     = acc_next[0];
            last_x_next       = acc_next[1];
            last_y_next       = acc_next[2];
            md_valid          = digits_seen_next[2];
            md_release        = in_byte == tekd_pkg::CH_LM;
            md_btn            = acc_next[0];
            md_x              = acc_next[1];
            md_y              = acc_next[2];
            phase_next        = tekd_pkg::PH_IDLE;
            has_res           = 1'b1;
            res_kind          = md_kind;
            res               = md_res;
          end
        end
        default: begin
          phase_next = tekd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tekd_pkg::PH_IDLE;
      held_digit   <= '0;
      held_mod     <= '0;
      rep_len      <= '0;
      field_idx    <= '0;
      digits_seen  <= '0;
      last_valid   <= 1'b0;
      last_release <= 1'b0;
      last_btn     <= '0;
      last_x       <= '0;
      last_y       <= '0;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
    end else if (process) begin
      phase        <= phase_next;
      held_digit   <= held_digit_next;
      held_mod     <= held_mod_next;
      rep_len      <= rep_len_next;
      field_idx    <= field_idx_next;
      digits_seen  <= digits_seen_next;
      last_valid   <= last_valid_next;
      last_release <= last_release_next;
      last_btn     <= last_btn_next;
      last_x       <= last_x_next;
      last_y       <= last_y_next;
      acc          <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= has_res;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (process) begin
      out_kind <= res_kind;
      out_res  <= res;
    end
  end

endmodule

### src/tekd_checker.sv
// Port-level checker for the terminal escape key decoder, with its bind.
`timescale 1ns / 1ps

module tekd_checker #(
  parameter int COORD_BITS = tekd_pkg::COORD_BITS,
  parameter int TDATA_W    = ((24 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  localparam int PR_BIT = 22 + 2 * COORD_BITS;
  localparam int RL_BIT = 23 + 2 * COORD_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_redraw_blank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tekd_pkg::KIND_REDRAW |-> m_axis_tdata == '0)
    else $error("redraw word carries data");

  a_key_no_mouse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tekd_pkg::KIND_KEY |->
      m_axis_tdata[TDATA_W-1:14] == '0)
    else $error("key word carries mouse fields");

  a_press_release: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[PR_BIT] && m_axis_tdata[RL_BIT]))
    else $error("mouse word both pressed and released");

endmodule

bind terminal_escape_key_decoder tekd_checker #(
  .COORD_BITS (COORD_BITS),
  .TDATA_W    (TDATA_W)
) u_tekd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
